// File: hw/rtl/amou_pkg.sv
// Shared types and constants of the atomic memory operation unit.
package amou_pkg;

    localparam int OPC_W  = 4;
    localparam int ADDR_W = 10;
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    typedef enum logic [OPC_W-1:0] {
        OP_READ   = 4'd0,
        OP_SWAP   = 4'd1,
        OP_CAS    = 4'd2,
        OP_ADD    = 4'd3,
        OP_AND    = 4'd4,
        OP_OR     = 4'd5,
        OP_XOR    = 4'd6,
        OP_TCLEAR = 4'd7,
        OP_TSET   = 4'd8
    } opcode_t;

    // Request fields that travel with an item through the pipeline.
    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [WORD_W-1:0] operand;
        logic [WORD_W-1:0] compare_value;
        logic [BIT_W-1:0]  bit_index;
    } op_t;

    typedef struct packed {
        logic [WORD_W-1:0] old_word;
        logic [WORD_W-1:0] new_word;
        logic              flag;
    } result_t;

endpackage

// File: hw/rtl/amou_if.sv
// Request and response channel interfaces.
interface amou_req_if;
    logic                               valid;
    logic                               ready;
    logic [amou_pkg::OPC_W-1:0]         opcode;
    logic [amou_pkg::ADDR_W-1:0]        address;
    logic [amou_pkg::WORD_W-1:0]        operand;
    logic [amou_pkg::WORD_W-1:0]        compare_value;
    logic [amou_pkg::BIT_W-1:0]         bit_index;

    modport source (
        output valid, opcode, address, operand, compare_value, bit_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, address, operand, compare_value, bit_index,
        output ready
    );
endinterface

interface amou_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [amou_pkg::WORD_W-1:0]        old_word;
    logic [amou_pkg::WORD_W-1:0]        new_word;
    logic                               flag;

    modport source (
        output valid, old_word, new_word, flag,
        input  ready
    );
    modport sink (
        input  valid, old_word, new_word, flag,
        output ready
    );
endinterface

// File: hw/rtl/amou_index.sv
// Two-stage reduction of the request address modulo the store depth.
module amou_index #(
    parameter int WORD_COUNT = 1024,
    parameter int IDX_W      = 10
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [amou_pkg::ADDR_W-1:0] address,
    output logic [IDX_W-1:0]            index
);
    localparam int AW = amou_pkg::ADDR_W;

    logic [IDX_W-1:0] index_reg;

    assign index = index_reg;

    generate
        if (WORD_COUNT >= (2 ** AW)) begin : g_direct
            logic [AW-1:0] addr_reg;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    addr_reg  <= address;
                    index_reg <= IDX_W'(addr_reg);
                end
            end
        end else begin : g_reduce
            // Quotient estimate by reciprocal; it is low by at most one.
            localparam int SHIFT   = 2 * AW;
            localparam int RECIP_W = SHIFT + 1;
            localparam int RECIP   = (2 ** SHIFT) / WORD_COUNT;
            localparam int PROD_W  = AW + RECIP_W;
            localparam int REM_W   = AW + 1;

            logic [AW-1:0]     addr_reg;
            logic [AW-1:0]     quot_reg;
            logic [PROD_W-1:0] recip_prod;
            logic [SHIFT:0]    back_prod;
            logic [REM_W-1:0]  rem_raw;
            logic [REM_W-1:0]  rem_fix;

            assign recip_prod = PROD_W'(address) * PROD_W'(RECIP);
            assign back_prod  = (SHIFT + 1)'(quot_reg) * (SHIFT + 1)'(WORD_COUNT);
            assign rem_raw    = REM_W'(addr_reg) - back_prod[REM_W-1:0];
            assign rem_fix    = (rem_raw >= REM_W'(WORD_COUNT))
                                ? rem_raw - REM_W'(WORD_COUNT) : rem_raw;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    addr_reg  <= address;
                    quot_reg  <= recip_prod[SHIFT +: AW];
                    index_reg <= IDX_W'(rem_fix);
                end
            end
        end
    endgenerate

endmodule

// File: hw/rtl/amou_store.sv
// Word store: one write and one registered read per cycle, swept to zero after reset.
module amou_store #(
    parameter int WORD_COUNT = 1024,
    parameter int IDX_W      = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [IDX_W-1:0]            rd_index,
    output logic [amou_pkg::WORD_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_index,
    input  logic [amou_pkg::WORD_W-1:0] wr_data,
    output logic                        clearing
);
    localparam int WW = amou_pkg::WORD_W;

    logic [WW-1:0]    mem [WORD_COUNT];
    logic [WW-1:0]    rd_data_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic             clearing_reg;

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == IDX_W'(WORD_COUNT - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_index] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_index];
        end
    end

endmodule

// File: hw/rtl/amou_alu.sv
// Modify step of the read-modify-write: new word and flag from the old word.
module amou_alu (
    input  logic [amou_pkg::WORD_W-1:0] prior,
    input  amou_pkg::op_t               op,
    output amou_pkg::result_t           res
);
    logic [amou_pkg::WORD_W-1:0] mask;
    logic                        prior_bit;

    assign mask      = amou_pkg::WORD_W'(1) << op.bit_index;
    assign prior_bit = prior[op.bit_index];

    always_comb
    begin
        res.old_word = prior;
        res.new_word = prior;
        res.flag     = 1'b0;
        unique case (op.opcode)
            amou_pkg::OP_SWAP:
                res.new_word = op.operand;
            amou_pkg::OP_CAS:
            begin
                if (prior == op.compare_value)
                begin
                    res.new_word = op.operand;
                    res.flag     = 1'b1;
                end
            end
            amou_pkg::OP_ADD:
                res.new_word = prior + op.operand;
            amou_pkg::OP_AND:
                res.new_word = prior & op.operand;
            amou_pkg::OP_OR:
                res.new_word = prior | op.operand;
            amou_pkg::OP_XOR:
                res.new_word = prior ^ op.operand;
            amou_pkg::OP_TCLEAR:
            begin
                res.new_word = prior & ~mask;
                res.flag     = prior_bit;
            end
            amou_pkg::OP_TSET:
            begin
                res.new_word = prior | mask;
                res.flag     = prior_bit;
            end
            default:
            begin
                res.new_word = prior;
            end
        endcase
    end

endmodule

// File: hw/rtl/atomic_memory_operation_unit.sv
// Top level of the atomic memory operation unit: pipeline control and forwarding.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+---------------------------------------------------
//  req     | in  | valid/ready | opcode, address, operand, compare_value, bit_index
//  rsp     | out | valid/ready | old_word, new_word, flag
//
// One request per cycle while req.ready is high; each stage below is registered.
// Stages: quotient estimate, index reduction and store read, modify and write back,
// output register. The store has one read and one write port; the last write is
// kept and forwarded to the next item when it hits the same word.
// After reset the store is swept to zero word by word; req.ready stays low meanwhile.
// A stalled rsp freezes the whole pipeline and drops req.ready.
module atomic_memory_operation_unit #(
    parameter int WORD_COUNT = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    amou_req_if.sink        req,
    amou_rsp_if.source      rsp
);
    localparam int IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int WW    = amou_pkg::WORD_W;

    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              ex_valid_reg;
    amou_pkg::op_t     s1_op_reg;
    amou_pkg::op_t     s2_op_reg;
    amou_pkg::op_t     ex_op_reg;
    logic [IDX_W-1:0]  ex_index_reg;

    logic              wb_valid_reg;
    logic [IDX_W-1:0]  wb_index_reg;
    logic [WW-1:0]     wb_data_reg;

    logic              out_valid_reg;
    amou_pkg::result_t out_res_reg;

    logic              adv;
    logic              accept;
    logic              store_clearing;
    logic [IDX_W-1:0]  s2_index;
    logic [WW-1:0]     rd_data;
    logic [WW-1:0]     prior;
    logic              ex_write;
    amou_pkg::op_t     req_op;
    amou_pkg::result_t alu_res;

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv && !store_clearing;
    assign accept    = req.valid && req.ready;
    assign ex_write  = adv && ex_valid_reg;

    assign req_op.opcode        = req.opcode;
    assign req_op.operand       = req.operand;
    assign req_op.compare_value = req.compare_value;
    assign req_op.bit_index     = req.bit_index;

    // Forward the last write: the store read may have raced it.
    assign prior = (wb_valid_reg && wb_index_reg == ex_index_reg) ? wb_data_reg : rd_data;

    amou_index #(
        .WORD_COUNT (WORD_COUNT),
        .IDX_W      (IDX_W)
    ) u_index (
        .clk     (clk),
        .en      (adv),
        .address (req.address),
        .index   (s2_index)
    );

    amou_store #(
        .WORD_COUNT (WORD_COUNT),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (adv && s2_valid_reg),
        .rd_index (s2_index),
        .rd_data  (rd_data),
        .wr_en    (ex_write),
        .wr_index (ex_index_reg),
        .wr_data  (alu_res.new_word),
        .clearing (store_clearing)
    );

    amou_alu u_alu (
        .prior (prior),
        .op    (ex_op_reg),
        .res   (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            ex_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            ex_valid_reg  <= s2_valid_reg;
            out_valid_reg <= ex_valid_reg;
            if (ex_valid_reg)
            begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg    <= req_op;
            s2_op_reg    <= s1_op_reg;
            ex_op_reg    <= s2_op_reg;
            ex_index_reg <= s2_index;
            if (ex_valid_reg)
            begin
                wb_index_reg <= ex_index_reg;
                wb_data_reg  <= alu_res.new_word;
                out_res_reg  <= alu_res;
            end
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.old_word = out_res_reg.old_word;
    assign rsp.new_word = out_res_reg.new_word;
    assign rsp.flag     = out_res_reg.flag;

    a_no_transfer_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        store_clearing |-> !accept
    ) else $error("request transfer during store clear");

    a_no_write_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        store_clearing |-> !ex_valid_reg
    ) else $error("modify stage active during store clear");

    a_failed_cas_keeps_word: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ex_valid_reg && ex_op_reg.opcode == amou_pkg::OP_CAS && !alu_res.flag)
            |-> (alu_res.new_word == prior)
    ) else $error("failed compare-swap changed the word");

    a_stall_holds_modify_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ex_valid_reg && !adv) |=> (ex_valid_reg && $stable(ex_index_reg))
    ) else $error("modify stage moved while output stalled");

endmodule

// File: verif/amou_checker.sv
// Checker for the atomic memory unit: watches both channels, predicts each result and compares.
module amou_checker #(
    parameter int WORD_COUNT = 1024
) (
    input  logic clk,
    input  logic rst_n,
    amou_req_if  req,
    amou_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding
);
    import amou_pkg::*;

    logic [WORD_W-1:0] shadow_mem [WORD_COUNT];
    result_t           pending_results [$];

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Apply one atomic operation to the shadow store and return old/new word and flag.
    function automatic result_t amo_predict(input logic [OPC_W-1:0]  op,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [WORD_W-1:0] operand,
                                            input logic [WORD_W-1:0] cmp,
                                            input logic [BIT_W-1:0]  bit_idx);
        int                idx;
        logic [WORD_W-1:0] prior;
        logic [WORD_W-1:0] next;
        logic [WORD_W-1:0] mask;
        logic              hit;
        result_t           res;
        idx   = int'(addr) % WORD_COUNT;
        prior = shadow_mem[idx];
        next  = prior;
        hit   = 1'b0;
        mask  = {{(WORD_W-1){1'b0}}, 1'b1} << bit_idx;
        case (op)
            OP_SWAP: next = operand;
            OP_CAS:
            begin
                if (prior == cmp)
                begin
                    next = operand;
                    hit  = 1'b1;
                end
            end
            OP_ADD: next = prior + operand;
            OP_AND: next = prior & operand;
            OP_OR:  next = prior | operand;
            OP_XOR: next = prior ^ operand;
            OP_TCLEAR:
            begin
                hit  = |(prior & mask);
                next = prior & ~mask;
            end
            OP_TSET:
            begin
                hit  = |(prior & mask);
                next = prior | mask;
            end
            default: ;  // read and the spare codes leave the word alone
        endcase
        shadow_mem[idx] = next;
        res.old_word = prior;
        res.new_word = next;
        res.flag     = hit;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            foreach (shadow_mem[i])
                shadow_mem[i] = '0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // Check the response transfer first: it belongs to an earlier request.
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending, old_word", rsp.old_word, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.old_word !== want.old_word)
                        report_mismatch("old_word", rsp.old_word, want.old_word);
                    if (rsp.new_word !== want.new_word)
                        report_mismatch("new_word", rsp.new_word, want.new_word);
                    if (rsp.flag !== want.flag)
                        report_mismatch("flag", WORD_W'(rsp.flag), WORD_W'(want.flag));
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(amo_predict(req.opcode, req.address, req.operand,
                                                      req.compare_value, req.bit_index));
            outstanding <= pending_results.size();
        end
    end

endmodule

// File: verif/tb.sv
// Testbench top: clock, reset, request stimulus, response back-pressure and the verdict.
module tb;
    import amou_pkg::*;

    localparam int WORD_COUNT   = 1024;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASE_COUNT  = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [OPC_W-1:0]  OP_SPARE_FIRST = 4'd9;
    localparam logic [OPC_W-1:0]  OP_SPARE_LAST  = 4'd15;
    localparam logic [WORD_W-1:0] ALL_ONES       = '1;
    localparam logic [ADDR_W-1:0] ADDR_TOP       = ADDR_W'(WORD_COUNT - 1);
    localparam logic [BIT_W-1:0]  BIT_TOP        = BIT_W'(WORD_W - 1);

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int mismatches;
    int outstanding;
    int sent = 0;
    logic [ADDR_W-1:0] hot_addr [4];

    amou_req_if req ();
    amou_rsp_if rsp ();

    atomic_memory_operation_unit #(.WORD_COUNT(WORD_COUNT)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    amou_checker #(.WORD_COUNT(WORD_COUNT)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);

    // Drive one request and hold it until the transfer happens.
    task automatic send_req(input logic [OPC_W-1:0]  op,
                            input logic [ADDR_W-1:0] addr,
                            input logic [WORD_W-1:0] operand,
                            input logic [WORD_W-1:0] cmp,
                            input logic [BIT_W-1:0]  bit_idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.opcode        <= op;
        req.address       <= addr;
        req.operand       <= operand;
        req.compare_value <= cmp;
        req.bit_index     <= bit_idx;
        do
            @(posedge clk);
        while (!req.ready);
        sent++;
    endtask

    // Drop valid and hold off until every result has come back.
    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return ALL_ONES;
            2: return WORD_W'($urandom_range(3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return hot_addr[$urandom_range(3)];
        else if (pick < 80)
            return ($urandom_range(1) != 0) ? ADDR_TOP : '0;
        return ADDR_W'($urandom_range(WORD_COUNT - 1));
    endfunction

    // Mostly swap, compare-swap usually on the known value, then a short run of ops on
    // same word; the rest is single requests with any opcode, spare codes included.
    task automatic run_random(input int count);
        int                stop;
        int                burst;
        logic [ADDR_W-1:0] a;
        logic [WORD_W-1:0] known;
        stop = sent + count;
        while (sent < stop)
        begin
            a = rand_addr();
            if ($urandom_range(99) < 60)
            begin
                known = rand_word();
                send_req(OP_SWAP, a, known, rand_word(), BIT_W'($urandom));
                send_req(OP_CAS, a, rand_word(),
                         ($urandom_range(3) == 0) ? rand_word() : known, BIT_W'($urandom));
                burst = $urandom_range(4);
                repeat (burst)
                    send_req(OPC_W'($urandom_range(OP_TSET)), a, rand_word(), rand_word(),
                             BIT_W'($urandom));
            end
            else
                send_req(OPC_W'($urandom_range(OP_SPARE_LAST)), a, rand_word(), rand_word(),
                         BIT_W'($urandom));
        end
    endtask

    initial
    begin
        req.valid         = 1'b0;
        req.opcode        = '0;
        req.address       = '0;
        req.operand       = '0;
        req.compare_value = '0;
        req.bit_index     = '0;
        foreach (hot_addr[i])
            hot_addr[i] = ADDR_W'($urandom_range(WORD_COUNT - 1));
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every opcode, wrap on add, compare-swap hit and miss.
        send_req(OP_READ,   '0,       ALL_ONES, ALL_ONES, BIT_TOP);
        send_req(OP_SWAP,   ADDR_TOP, ALL_ONES, '0,       '0);
        send_req(OP_ADD,    ADDR_TOP, 64'd1,    '0,       '0);
        send_req(OP_ADD,    ADDR_TOP, ALL_ONES, '0,       '0);
        send_req(OP_CAS,    ADDR_TOP, 64'h0123_4567_89AB_CDEF, ALL_ONES, '0);
        send_req(OP_CAS,    ADDR_TOP, '0,       ALL_ONES, '0);
        send_req(OP_SWAP,   '0,       64'hA5A5_A5A5_A5A5_A5A5, '0, '0);
        send_req(OP_AND,    '0,       64'h0F0F_0F0F_0F0F_0F0F, '0, '0);
        send_req(OP_OR,     '0,       64'hF000_0000_0000_0000, '0, '0);
        send_req(OP_XOR,    '0,       ALL_ONES, '0,       '0);
        send_req(OP_TSET,   10'd5,    ALL_ONES, ALL_ONES, '0);
        send_req(OP_TSET,   10'd5,    '0,       '0,       BIT_TOP);
        send_req(OP_TSET,   10'd5,    '0,       '0,       BIT_TOP);
        send_req(OP_TCLEAR, 10'd5,    ALL_ONES, ALL_ONES, '0);
        send_req(OP_TCLEAR, 10'd5,    '0,       '0,       '0);
        send_req(OP_TCLEAR, 10'd5,    '0,       '0,       BIT_TOP);
        send_req(OP_SPARE_FIRST, 10'd5, ALL_ONES, ALL_ONES, BIT_TOP);
        send_req(OP_SPARE_LAST, ADDR_TOP, ALL_ONES, ALL_ONES, BIT_TOP);
        send_req(OP_READ,   ADDR_TOP, '0,       ALL_ONES, BIT_TOP);
        send_req(OP_SWAP,   10'd512,  '0,       ALL_ONES, BIT_TOP);
        send_req(OP_CAS,    10'd512,  ALL_ONES, '0,       '0);
        send_req(OP_READ,   10'd512,  '0,       '0,       '0);
        wait_drained();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 86;
                    rsp_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct = 29;
                    rsp_stall_pct = 29;
                end
            endcase
            foreach (hot_addr[i])
                hot_addr[i] = ADDR_W'($urandom_range(WORD_COUNT - 1));
            run_random(RANDOM_ITEMS / PHASE_COUNT);
            if (ph % 2 == 1)
                wait_drained();
        end

        send_idle_pct = 0;
        rsp_stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (CYCLE_LIMIT)
            @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/amou_pkg.sv
hw/rtl/amou_if.sv
hw/rtl/amou_index.sv
hw/rtl/amou_store.sv
hw/rtl/amou_alu.sv
hw/rtl/atomic_memory_operation_unit.sv
verif/amou_checker.sv
verif/tb.sv
